>>> rtl/ofb_pkg.sv
// ----------------------------------------------------------------------------
// ofb_pkg
// shared types, codes and constants of the page-mode frame buffer
// ----------------------------------------------------------------------------
package ofb_pkg;

  localparam int DEF_WIDTH = 128;
  localparam int DEF_PAGES = 4;
  localparam int DEF_CHIPS = 4;

  // bytes in one bundle
  localparam int BUNDLE = 16;

  // display command bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // operation codes
  localparam logic [1:0] OP_POINT   = 2'd0;
  localparam logic [1:0] OP_BLIT    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_REFRESH = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] blit_width;
    logic       mode;
    logic [7:0] bitmap_byte;
    logic       first;
    logic       final_req;
    logic [1:0] chip;
  } item_t;

  typedef struct packed {
    logic        is_data;
    logic [4:0]  byte_count;
    logic [63:0] bytes_low;
    logic [63:0] bytes_high;
    logic [1:0]  chip_out;
    logic        last;
  } bundle_t;

  // read-modify-write plan for one drawing item (up to two page bytes)
  typedef struct packed {
    logic       en0;
    logic       en1;
    logic [7:0] mask0;
    logic [7:0] mask1;
    logic [7:0] val0;
    logic [7:0] val1;
    logic       blit;
    logic       fin;
  } plan_t;

  // bits of the page field of a store address
  function automatic int page_bits(input int pages);
    return (pages > 1) ? $clog2(pages) : 1;
  endfunction

endpackage

>>> rtl/ofb_ram.sv
// ----------------------------------------------------------------------------
// ofb_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ofb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ofb_draw.sv
// ----------------------------------------------------------------------------
// ofb_draw
// blit cursor and per-item write plan for point and blit items
// ----------------------------------------------------------------------------
module ofb_draw #(
  parameter int WIDTH = ofb_pkg::DEF_WIDTH,
  parameter int PAGES = ofb_pkg::DEF_PAGES,
  parameter int ADDR_W = $clog2(WIDTH) + ofb_pkg::page_bits(PAGES)
) (
  input  logic                clk,
  input  logic                rst,
  input  ofb_pkg::item_t      item,
  input  logic                accept,
  output logic [ADDR_W-1:0]   addr_now,
  output logic [ADDR_W-1:0]   addr0,
  output logic [ADDR_W-1:0]   addr1,
  output ofb_pkg::plan_t      plan
);

  localparam int COL_W  = $clog2(WIDTH);
  localparam int PAGE_W = ofb_pkg::page_bits(PAGES);

  logic [7:0] cursor_column;
  logic [7:0] cursor_row;
  logic [7:0] origin_column;
  logic [7:0] active_width;

  logic                is_blit;
  logic                use_cursor;
  logic [7:0]          col;
  logic [7:0]          row;
  logic [7:0]          origin_eff;
  logic [7:0]          width_eff;
  logic [7:0]          pix;
  logic [15:0]         wide_m;
  logic [15:0]         wide_v;
  logic [4:0]          p0;
  logic [4:0]          p1;
  logic                col_ok;
  logic [7:0]          col_inc;
  logic                wrap;
  logic [ADDR_W-1:0]   addr1_now;
  ofb_pkg::plan_t      plan_next;

  always_comb begin
    is_blit    = (item.operation == ofb_pkg::OP_BLIT);
    use_cursor = is_blit && !item.first;
    col        = use_cursor ? cursor_column : item.x;
    row        = use_cursor ? cursor_row : item.y;
    origin_eff = use_cursor ? origin_column : item.x;
    if (use_cursor) begin
      width_eff = active_width;
    end else if (item.blit_width == 8'd0) begin
      width_eff = 8'd1;
    end else begin
      width_eff = item.blit_width;
    end
    pix = item.mode ? item.bitmap_byte : ~item.bitmap_byte;
    if (is_blit) begin
      wide_m = 16'h00FF << row[2:0];
      wide_v = {8'h00, pix} << row[2:0];
    end else begin
      wide_m = 16'h0001 << row[2:0];
      wide_v = {16{item.mode}};
    end
    p0     = row[7:3];
    p1     = p0 + 5'd1;
    col_ok = {1'b0, col} < 9'(WIDTH);
    addr_now  = {col[COL_W-1:0], p0[PAGE_W-1:0]};
    addr1_now = {col[COL_W-1:0], p1[PAGE_W-1:0]};

    plan_next.en0   = col_ok && (p0 < 5'(PAGES));
    plan_next.en1   = is_blit && col_ok && (p1 < 5'(PAGES)) && (row[2:0] != 3'd0);
    plan_next.mask0 = wide_m[7:0];
    plan_next.mask1 = wide_m[15:8];
    plan_next.val0  = wide_v[7:0];
    plan_next.val1  = wide_v[15:8];
    plan_next.blit  = is_blit;
    plan_next.fin   = is_blit && item.final_req;

    col_inc = col + 8'd1;
    wrap    = ((col_inc - origin_eff) == width_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= 8'd0;
      cursor_row    <= 8'd0;
      origin_column <= 8'd0;
      active_width  <= 8'd1;
    end else if (accept) begin
      plan  <= plan_next;
      addr0 <= addr_now;
      addr1 <= addr1_now;
      if (is_blit) begin
        origin_column <= origin_eff;
        active_width  <= width_eff;
        // return to the origin column one page band lower
        if (wrap) begin
          cursor_column <= origin_eff;
          cursor_row    <= row + 8'd8;
        end else begin
          cursor_column <= col_inc;
          cursor_row    <= row;
        end
      end
    end
  end

endmodule

>>> rtl/ofb_refresh.sv
// ----------------------------------------------------------------------------
// ofb_refresh
// walks the store page by page and emits command and data bundles
// ----------------------------------------------------------------------------
module ofb_refresh #(
  parameter int WIDTH  = ofb_pkg::DEF_WIDTH,
  parameter int PAGES  = ofb_pkg::DEF_PAGES,
  parameter int ADDR_W = $clog2(WIDTH) + ofb_pkg::page_bits(PAGES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        chip,
  output logic              busy,
  output logic [ADDR_W-1:0] raddr,
  input  logic [7:0]        rdata,
  output ofb_pkg::bundle_t  bundle,
  output logic              bundle_valid,
  input  logic              bundle_stall
);

  localparam int COL_W  = $clog2(WIDTH);
  localparam int PAGE_W = ofb_pkg::page_bits(PAGES);
  localparam int CNT_W  = $clog2(WIDTH + 1);

  typedef enum logic [1:0] {R_IDLE, R_CMD, R_READ, R_EMIT} rstate_t;

  rstate_t                 state;
  logic [PAGE_W-1:0]       page;
  logic [CNT_W-1:0]        col_base;
  logic [4:0]              idx;
  logic                    cap_vld;
  logic [3:0]              cap_pos;
  logic [8*ofb_pkg::BUNDLE-1:0] gather;
  logic [1:0]              chip_q;

  logic [CNT_W-1:0]        rem;
  logic [4:0]              count;
  logic [CNT_W-1:0]        end_col;
  logic [CNT_W-1:0]        rd_col;
  logic                    group_last;
  logic                    page_last;
  logic                    slot_free;

  always_comb begin
    rem        = CNT_W'(WIDTH) - col_base;
    count      = (rem > CNT_W'(ofb_pkg::BUNDLE)) ? 5'(ofb_pkg::BUNDLE) : rem[4:0];
    end_col    = col_base + CNT_W'(count);
    group_last = (end_col == CNT_W'(WIDTH));
    page_last  = (page == PAGE_W'(PAGES - 1));
    rd_col     = col_base + CNT_W'(idx);
    raddr      = {rd_col[COL_W-1:0], page};
    slot_free  = !bundle_valid || !bundle_stall;
    busy       = (state != R_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= R_IDLE;
      bundle_valid <= 1'b0;
      cap_vld      <= 1'b0;
    end else begin
      if (bundle_valid && !bundle_stall) begin
        bundle_valid <= 1'b0;
      end
      cap_vld <= 1'b0;
      if (cap_vld) begin
        gather[cap_pos*8 +: 8] <= rdata;
      end
      case (state)
        R_IDLE: begin
          if (start) begin
            chip_q   <= chip;
            page     <= '0;
            col_base <= '0;
            state    <= R_CMD;
          end
        end
        R_CMD: begin
          if (slot_free) begin
            bundle_valid       <= 1'b1;
            bundle.is_data     <= 1'b0;
            bundle.byte_count  <= 5'd3;
            bundle.bytes_low   <= {40'd0, ofb_pkg::CMD_COL_HIGH, ofb_pkg::CMD_COL_LOW,
                                   ofb_pkg::CMD_PAGE_BASE + 8'(page)};
            bundle.bytes_high  <= 64'd0;
            bundle.chip_out    <= chip_q;
            bundle.last        <= 1'b0;
            gather             <= '0;
            idx                <= 5'd0;
            state              <= R_READ;
          end
        end
        R_READ: begin
          if (idx < count) begin
            cap_vld <= 1'b1;
            cap_pos <= idx[3:0];
            idx     <= idx + 5'd1;
          end else begin
            // final byte lands at this edge
            state <= R_EMIT;
          end
        end
        R_EMIT: begin
          if (slot_free) begin
            bundle_valid       <= 1'b1;
            bundle.is_data     <= 1'b1;
            bundle.byte_count  <= count;
            bundle.bytes_low   <= gather[63:0];
            bundle.bytes_high  <= gather[127:64];
            bundle.chip_out    <= chip_q;
            bundle.last        <= group_last && page_last;
            gather             <= '0;
            idx                <= 5'd0;
            if (!group_last) begin
              col_base <= end_col;
              state    <= R_READ;
            end else if (page_last) begin
              state <= R_IDLE;
            end else begin
              col_base <= '0;
              page     <= page + PAGE_W'(1);
              state    <= R_CMD;
            end
          end
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/oled_page_frame_buffer.sv
// ----------------------------------------------------------------------------
// oled_page_frame_buffer
// page-organized monochrome frame store with a refresh bundle stream
// ----------------------------------------------------------------------------
// items: a point item is one read-modify-write of the frame ram, a blit byte
//   one per touched page byte; the ram read port is registered
// refresh: paced by the single ram read port, and held while the bundle
//   side stalls
// reset: a clearing pass over all (WIDTH << page bits) words zeroes the ram, no
//   item is taken meanwhile; a clear item runs the same pass, then refreshes
// ----------------------------------------------------------------------------
module oled_page_frame_buffer #(
  parameter int WIDTH = ofb_pkg::DEF_WIDTH,
  parameter int PAGES = ofb_pkg::DEF_PAGES,
  parameter int CHIPS = ofb_pkg::DEF_CHIPS
) (
  input  logic             clk,
  input  logic             rst,
  input  ofb_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_stall,
  output ofb_pkg::bundle_t bundle,
  output logic             bundle_valid,
  input  logic             bundle_stall
);

  // store address is {column, page}, so no multiply is needed
  localparam int COL_W  = $clog2(WIDTH);
  localparam int PAGE_W = ofb_pkg::page_bits(PAGES);
  localparam int ADDR_W = COL_W + PAGE_W;
  localparam int DEPTH  = WIDTH << PAGE_W;

  typedef enum logic [2:0] {T_CLEAR, T_IDLE, T_WR0, T_WR1, T_REF} tstate_t;

  tstate_t            state;
  logic [ADDR_W-1:0]  sweep;
  logic               ref_pending;
  logic [1:0]         chip_q;

  logic               accept;
  logic [1:0]         chip_now;
  logic               sweep_end;

  logic [ADDR_W-1:0]  addr_now;
  logic [ADDR_W-1:0]  addr0;
  logic [ADDR_W-1:0]  addr1;
  ofb_pkg::plan_t     plan;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [7:0]         wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [7:0]         rdata;

  logic               ref_start;
  logic [1:0]         ref_chip;
  logic               ref_busy;
  logic [ADDR_W-1:0]  ref_raddr;

  // items are taken only while idle
  assign item_stall = (state != T_IDLE);
  assign accept     = item_valid && !item_stall;
  assign sweep_end  = (sweep == ADDR_W'(DEPTH - 1));

  // fold an out-of-range chip select back into range, at most three steps
  always_comb begin
    chip_now = item.chip;
    for (int i = 0; i < 3; i++) begin
      if (int'(chip_now) >= CHIPS) begin
        chip_now = chip_now - 2'(CHIPS);
      end
    end
  end

  // cursor and per-item write plan
  ofb_draw #(
    .WIDTH  (WIDTH),
    .PAGES  (PAGES),
    .ADDR_W (ADDR_W)
  ) u_draw (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .accept   (accept),
    .addr_now (addr_now),
    .addr0    (addr0),
    .addr1    (addr1),
    .plan     (plan)
  );

  // ram port steering
  always_comb begin
    we    = 1'b0;
    waddr = addr0;
    wdata = (rdata & ~plan.mask0) | (plan.val0 & plan.mask0);
    case (state)
      T_CLEAR: begin
        we    = 1'b1;
        waddr = sweep;
        wdata = 8'd0;
      end
      T_WR0: begin
        we = plan.en0;
      end
      T_WR1: begin
        we    = plan.en1;
        waddr = addr1;
        wdata = (rdata & ~plan.mask1) | (plan.val1 & plan.mask1);
      end
      default: begin
        we = 1'b0;
      end
    endcase

    // idle reads the first page byte of the incoming item, the first write
    // cycle reads the second one of a blit
    case (state)
      T_IDLE:  raddr = addr_now;
      T_WR0:   raddr = addr1;
      T_REF:   raddr = ref_raddr;
      default: raddr = ref_raddr;
    endcase

    ref_start = ((state == T_CLEAR) && sweep_end && ref_pending)
             || (accept && (item.operation == ofb_pkg::OP_REFRESH))
             || ((state == T_WR1) && plan.fin);
    ref_chip  = (state == T_IDLE) ? chip_now : chip_q;
  end

  ofb_ram #(
    .DATA_W (8),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // refresh walker owns the read port while it runs
  ofb_refresh #(
    .WIDTH  (WIDTH),
    .PAGES  (PAGES),
    .ADDR_W (ADDR_W)
  ) u_refresh (
    .clk          (clk),
    .rst          (rst),
    .start        (ref_start),
    .chip         (ref_chip),
    .busy         (ref_busy),
    .raddr        (ref_raddr),
    .rdata        (rdata),
    .bundle       (bundle),
    .bundle_valid (bundle_valid),
    .bundle_stall (bundle_stall)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_CLEAR;
      sweep       <= '0;
      ref_pending <= 1'b0;
    end else begin
      case (state)
        T_CLEAR: begin
          sweep <= sweep + ADDR_W'(1);
          if (sweep_end) begin
            ref_pending <= 1'b0;
            state       <= ref_pending ? T_REF : T_IDLE;
          end
        end
        T_IDLE: begin
          if (accept) begin
            chip_q <= chip_now;
            case (item.operation)
              ofb_pkg::OP_POINT: state <= T_WR0;
              ofb_pkg::OP_BLIT:  state <= T_WR0;
              ofb_pkg::OP_CLEAR: begin
                sweep       <= '0;
                ref_pending <= 1'b1;
                state       <= T_CLEAR;
              end
              default: state <= T_REF;
            endcase
          end
        end
        T_WR0: begin
          state <= plan.blit ? T_WR1 : T_IDLE;
        end
        T_WR1: begin
          // a final blit byte hands over to the refresh walker
          state <= plan.fin ? T_REF : T_IDLE;
        end
        T_REF: begin
          if (!ref_busy) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule
